// File: hw/rtl/acg_pkg.sv
// acg_pkg: widths, register map and reset values for the compander envelope/gain block.
// No dependencies; used by the channel interfaces and the top level.
package acg_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int COEFF_BITS    = 24;
	localparam int COEFF_LO_BITS = COEFF_BITS / 2;
	localparam int THR_BITS      = 16;
	localparam int GAIN_BITS     = 16;
	localparam int GAIN_FRAC     = 14;
	localparam int ENV_FRAC      = 9;
	localparam int ENV_BITS      = SAMPLE_BITS + ENV_FRAC;      // |sample| << 9 fits
	localparam int EXP_SHIFT     = 5;                            // expand: (env << 5) / T
	localparam int QUO_BITS      = 30;                           // quotient bits produced
	localparam int CMP_REM_SHIFT = 7;                            // (T << 37) >> QUO_BITS
	localparam int ROOT_BITS     = QUO_BITS / 2;
	localparam int MUL_A_BITS    = ENV_BITS;
	localparam int MUL_B_BITS    = GAIN_BITS;
	localparam int MUL_P_BITS    = MUL_A_BITS + MUL_B_BITS;
	localparam int PROD_BITS     = ENV_BITS + COEFF_BITS;
	localparam int SUB_BITS      = ENV_BITS + 2;
	localparam int CNT_BITS      = 5;
	localparam int ADDR_BITS     = 5;
	localparam int DATA_BITS     = 32;

	localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'd16384;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_ATTACK  = 3'd0;
	localparam logic [2:0] REG_RELEASE = 3'd1;
	localparam logic [2:0] REG_THRESH  = 3'd2;
	localparam logic [2:0] REG_FLOOR   = 3'd3;
	localparam logic [2:0] REG_CEIL    = 3'd4;

	localparam logic [COEFF_BITS-1:0] ATTACK_RST  = 24'd376156;
	localparam logic [COEFF_BITS-1:0] RELEASE_RST = 24'd7607;
	localparam logic [THR_BITS-1:0]   THRESH_RST  = 16'd3277;
	localparam logic [GAIN_BITS-1:0]  FLOOR_RST   = 16'd1638;
	localparam logic [GAIN_BITS-1:0]  CEIL_RST    = 16'd49152;

	localparam logic OP_COMPRESS = 1'b0;
	localparam logic OP_EXPAND   = 1'b1;

endpackage

// File: hw/rtl/acg_req_if.sv
// acg_req_if: request channel carrying one input sample and its path select.
// Depends on acg_pkg.
interface acg_req_if import acg_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output op, output sample_in, input ready);
	modport sink   (input valid, input op, input sample_in, output ready);
endinterface

// File: hw/rtl/acg_res_if.sv
// acg_res_if: result channel carrying the scaled sample, gain and clip flag.
// Depends on acg_pkg.
interface acg_res_if import acg_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic        [GAIN_BITS-1:0]   gain_applied;
	logic                          saturated;

	modport source (output valid, output sample_out, output gain_applied, output saturated,
		input ready);
	modport sink   (input valid, input sample_out, input gain_applied, input saturated,
		output ready);
endinterface

// File: hw/rtl/audio_compander_envelope_gain.sv
// audio_compander_envelope_gain: peak-envelope compander with fixed 2:1 ratio.
// Depends on acg_pkg, acg_req_if, acg_res_if.
//
// Usage:
//   sample_ch (sink) takes one request per sample: op selects the compress (0) or
//   expand (1) path, sample_in is signed Q1.15. result_ch (source) returns one
//   result per request: sample_out, the Q2.14 gain_applied and a clip flag.
//   The APB port holds attack/release coefficients, threshold, gain floor and
//   ceiling at byte addresses 0,4,8,12,16; write only while the block is idle.
// Timing:
//   A request is taken only while the sequencer is idle. When the envelope is
//   under threshold no divide runs and the gain stays unity; the expand path
//   runs a 30-step divide, the compress path the divide plus a 15-step square
//   root. The next request is taken the cycle after the result is registered.
//   The bit-serial divide and root share the one subtractor.
// Reset: both envelopes clear to zero, registers load their defaults.
// Stall: the result sits in an output register; a new request is accepted and
//   processed meanwhile, and the sequencer waits only if it finishes before the
//   previous result has been taken.
module audio_compander_envelope_gain import acg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	acg_req_if.sink              sample_ch,
	acg_res_if.source            result_ch,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_DIFF   = 11'b000_0000_0010,
		S_MUL_LO = 11'b000_0000_0100,
		S_MUL_HI = 11'b000_0000_1000,
		S_ENV    = 11'b000_0001_0000,
		S_GSEL   = 11'b000_0010_0000,
		S_DIV    = 11'b000_0100_0000,
		S_SQRT   = 11'b000_1000_0000,
		S_CLAMP  = 11'b001_0000_0000,
		S_APPLY  = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	// configuration registers
	logic [COEFF_BITS-1:0] attack_q, release_q;
	logic [THR_BITS-1:0]   thresh_q;
	logic [GAIN_BITS-1:0]  floor_q, ceil_q;

	// per-path envelopes
	logic [ENV_BITS-1:0] cmp_env_q, exp_env_q;

	// sequencer and datapath
	state_t                state_q;
	logic                  op_q, neg_q, up_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [ENV_BITS-1:0]   env_q, diff_q, den_q, rem_q;
	logic [COEFF_BITS-1:0] coeff_q;
	logic [THR_BITS-1:0]   thr_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [QUO_BITS-1:0]   shreg_q;
	logic [ROOT_BITS-1:0]  root_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic [CNT_BITS-1:0]   cnt_q;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic [GAIN_BITS-1:0]          out_gain_q;
	logic                          out_sat_q;

	// combinational helpers
	logic                  cfg_wr;
	logic                  req_take;
	logic                  out_free;
	logic [SAMPLE_BITS-1:0] in_mag;
	logic [ENV_BITS-1:0]   target;
	logic [ENV_BITS-1:0]   env_next;
	logic [ENV_BITS-1:0]   thr_env;
	logic [MUL_A_BITS-1:0] mul_a;
	logic [MUL_B_BITS-1:0] mul_b;
	logic [MUL_P_BITS-1:0] mul_p;
	logic [SUB_BITS-1:0]   sub_a, sub_b;
	logic [SUB_BITS:0]     sub_res;
	logic                  sub_ok;
	logic [ENV_BITS:0]     div_part;
	logic [ROOT_BITS+3:0]  sq_part;
	logic [QUO_BITS-1:0]   graw;
	logic [SAMPLE_BITS+1:0] scaled;
	logic signed [SAMPLE_BITS-1:0] res_val;
	logic                  res_sat;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign req_take = sample_ch.valid & sample_ch.ready;
	assign out_free = ~out_valid_q | result_ch.ready;

	assign sample_ch.ready     = (state_q == S_IDLE);
	assign result_ch.valid     = out_valid_q;
	assign result_ch.sample_out   = out_sample_q;
	assign result_ch.gain_applied = out_gain_q;
	assign result_ch.saturated    = out_sat_q;

	// register read-back
	always_comb begin
		unique case (paddr[4:2])
			REG_ATTACK:  prdata = DATA_BITS'(attack_q);
			REG_RELEASE: prdata = DATA_BITS'(release_q);
			REG_THRESH:  prdata = DATA_BITS'(thresh_q);
			REG_FLOOR:   prdata = DATA_BITS'(floor_q);
			REG_CEIL:    prdata = DATA_BITS'(ceil_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
			thresh_q  <= THRESH_RST;
			floor_q   <= FLOOR_RST;
			ceil_q    <= CEIL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_ATTACK:  attack_q  <= pwdata[COEFF_BITS-1:0];
				REG_RELEASE: release_q <= pwdata[COEFF_BITS-1:0];
				REG_THRESH:  thresh_q  <= pwdata[THR_BITS-1:0];
				REG_FLOOR:   floor_q   <= pwdata[GAIN_BITS-1:0];
				REG_CEIL:    ceil_q    <= pwdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// two's complement magnitude; -32768 maps to 32768
	assign in_mag = sample_ch.sample_in[SAMPLE_BITS-1]
		? (~sample_ch.sample_in + 1'b1) : sample_ch.sample_in;
	assign target  = {mag_q, {ENV_FRAC{1'b0}}};
	assign thr_env = {thr_q, {ENV_FRAC{1'b0}}};
	assign env_next = up_q ? (env_q + prod_q[PROD_BITS-1:COEFF_BITS])
		: (env_q - prod_q[PROD_BITS-1:COEFF_BITS]);

	// shared multiplier: coefficient halves for the envelope step, then sample * gain
	always_comb begin
		unique case (state_q)
			S_MUL_LO: begin
				mul_a = diff_q;
				mul_b = MUL_B_BITS'(coeff_q[COEFF_LO_BITS-1:0]);
			end
			S_MUL_HI: begin
				mul_a = diff_q;
				mul_b = MUL_B_BITS'(coeff_q[COEFF_BITS-1:COEFF_LO_BITS]);
			end
			S_APPLY: begin
				mul_a = MUL_A_BITS'(mag_q);
				mul_b = gain_q;
			end
			default: begin
				mul_a = diff_q;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// shared subtractor: one restoring divide step or one square-root step
	assign div_part = {rem_q, shreg_q[QUO_BITS-1]};
	assign sq_part  = {rem_q[ROOT_BITS+1:0], shreg_q[QUO_BITS-1:QUO_BITS-2]};
	always_comb begin
		if (state_q == S_SQRT) begin
			sub_a = SUB_BITS'(sq_part);
			sub_b = SUB_BITS'({root_q, 2'b01});
		end else begin
			sub_a = SUB_BITS'(div_part);
			sub_b = SUB_BITS'(den_q);
		end
	end
	assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ok  = ~sub_res[SUB_BITS];

	assign graw = (op_q == OP_EXPAND) ? shreg_q : QUO_BITS'(root_q);

	// truncate the product and saturate to the sample range
	assign scaled = prod_q[GAIN_FRAC+SAMPLE_BITS+1:GAIN_FRAC];
	always_comb begin
		res_sat = 1'b0;
		if (neg_q) begin
			if (scaled > (SAMPLE_BITS+2)'(1 << (SAMPLE_BITS-1))) begin
				res_sat = 1'b1;
				res_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			end else begin
				res_val = SAMPLE_BITS'(~scaled + 1'b1);
			end
		end else begin
			if (scaled > (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1)) begin
				res_sat = 1'b1;
				res_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			end else begin
				res_val = SAMPLE_BITS'(scaled);
			end
		end
	end

	// envelopes and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cmp_env_q   <= '0;
			exp_env_q   <= '0;
		end else begin
			// a new result replaces the one being taken in the same cycle
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && result_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (req_take) state_q <= S_DIFF;
				S_DIFF:   state_q <= S_MUL_LO;
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_ENV;
				S_ENV: begin
					state_q <= S_GSEL;
					if (op_q == OP_EXPAND)
						exp_env_q <= env_next;
					else
						cmp_env_q <= env_next;
				end
				S_GSEL:   state_q <= (env_q < thr_env) ? S_APPLY : S_DIV;
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= (op_q == OP_EXPAND) ? S_CLAMP : S_SQRT;
				end
				S_SQRT:   if (cnt_q == '0) state_q <= S_CLAMP;
				S_CLAMP:  state_q <= S_APPLY;
				S_APPLY:  state_q <= S_OUT;
				S_OUT:    if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_take) begin
					op_q  <= sample_ch.op;
					neg_q <= sample_ch.sample_in[SAMPLE_BITS-1];
					mag_q <= in_mag;
					env_q <= (sample_ch.op == OP_EXPAND) ? exp_env_q : cmp_env_q;
				end
			end
			S_DIFF: begin
				up_q    <= (target >= env_q);
				coeff_q <= (target > env_q) ? attack_q : release_q;
				diff_q  <= (target >= env_q) ? (target - env_q) : (env_q - target);
				thr_q   <= (thresh_q == '0) ? THR_BITS'(1) : thresh_q;
			end
			S_MUL_LO: prod_q <= PROD_BITS'(mul_p);
			S_MUL_HI: prod_q <= prod_q
				+ {mul_p[PROD_BITS-COEFF_LO_BITS-1:0], {COEFF_LO_BITS{1'b0}}};
			S_ENV:    env_q  <= env_next;
			S_GSEL: begin
				gain_q <= GAIN_ONE;
				cnt_q  <= CNT_BITS'(QUO_BITS - 1);
				if (op_q == OP_EXPAND) begin
					// (env << 5) / T
					den_q   <= ENV_BITS'(thr_q);
					rem_q   <= '0;
					shreg_q <= {env_q, {EXP_SHIFT{1'b0}}};
				end else begin
					// (T << 37) / env
					den_q   <= env_q;
					rem_q   <= ENV_BITS'({thr_q, {CMP_REM_SHIFT{1'b0}}});
					shreg_q <= '0;
				end
			end
			S_DIV: begin
				shreg_q <= {shreg_q[QUO_BITS-2:0], sub_ok};
				if (cnt_q == '0) begin
					// last quotient bit; set up the root over the quotient
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
				end else begin
					rem_q  <= sub_ok ? sub_res[ENV_BITS-1:0] : div_part[ENV_BITS-1:0];
					cnt_q  <= cnt_q - 1'b1;
				end
			end
			S_SQRT: begin
				rem_q   <= sub_ok ? ENV_BITS'(sub_res[ROOT_BITS+3:0]) : ENV_BITS'(sq_part);
				root_q  <= {root_q[ROOT_BITS-2:0], sub_ok};
				shreg_q <= {shreg_q[QUO_BITS-3:0], 2'b00};
				cnt_q   <= cnt_q - 1'b1;
			end
			S_CLAMP: begin
				// floor test wins when floor is above ceiling
				if (graw < QUO_BITS'(floor_q))
					gain_q <= floor_q;
				else if (graw > QUO_BITS'(ceil_q))
					gain_q <= ceil_q;
				else
					gain_q <= graw[GAIN_BITS-1:0];
			end
			S_APPLY:  prod_q <= PROD_BITS'(mul_p);
			S_OUT: begin
				if (out_free) begin
					out_sample_q <= res_val;
					out_gain_q   <= gain_q;
					out_sat_q    <= res_sat;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: dv/audio_compander_envelope_gain_tb.sv
`timescale 1ns / 100ps
// audio_compander_envelope_gain_tb: self-checking bench for the peak-envelope compander.
// Depends on acg_pkg, acg_req_if, acg_res_if and the audio_compander_envelope_gain RTL.
module audio_compander_envelope_gain_tb;
	import acg_pkg::*;

	// Addresses past the last register; writes there must have no effect.
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_MID = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam int MAX_IDLE      = 13;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 75;
	localparam int REPORT_LIMIT  = 10;

	// Signed output limits at the sample width.
	localparam logic [63:0] POS_LIMIT = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
	localparam logic [63:0] NEG_LIMIT = 64'd1 << (SAMPLE_BITS - 1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic        [GAIN_BITS-1:0]   gain_applied;
		logic                          saturated;
	} result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	acg_req_if sample_ch ();
	acg_res_if result_ch ();

	audio_compander_envelope_gain dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the register file and of both envelopes, as the block should hold them.
	logic [COEFF_BITS-1:0] cfg_attack;
	logic [COEFF_BITS-1:0] cfg_release;
	logic [THR_BITS-1:0]   cfg_thresh;
	logic [GAIN_BITS-1:0]  cfg_floor;
	logic [GAIN_BITS-1:0]  cfg_ceil;
	logic [ENV_BITS-1:0]   env_comp;
	logic [ENV_BITS-1:0]   env_exp;

	result_t pending_results[$];   // one entry per accepted request, oldest first
	int      mismatch_count;
	bit      calm;                 // when set, neither side idles

	// Truncated integer square root, built bit by bit from the top.
	// Operand stays below 2^54, so the root fits 28 bits.
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] cand;
		r = 64'd0;
		for (int b = 27; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand * cand <= v)
				r = cand;
		end
		return r;
	endfunction

	// Envelope moves toward |sample| << 9; attack when rising, release otherwise.
	// The step is truncated, so it never overshoots the target.
	function automatic logic [ENV_BITS-1:0] track_envelope(input logic [ENV_BITS-1:0] env,
		input logic [63:0] mag);
		logic [63:0] target;
		logic [63:0] cur;
		logic [63:0] coeff;
		logic [63:0] step;
		target = mag << ENV_FRAC;
		cur = 64'(env);
		coeff = (target > cur) ? 64'(cfg_attack) : 64'(cfg_release);
		if (target >= cur) begin
			step = ((target - cur) * coeff) >> COEFF_BITS;
			cur = cur + step;
		end else begin
			step = ((cur - target) * coeff) >> COEFF_BITS;
			cur = cur - step;
		end
		return cur[ENV_BITS-1:0];
	endfunction

	// 2:1 gain law in Q2.14. Under threshold: unity, no clamp.
	// Floor is tested before ceiling, so with an inverted pair a gain under the floor takes the floor.
	function automatic logic [GAIN_BITS-1:0] gain_for_env(input logic [ENV_BITS-1:0] env,
		input logic op);
		logic [63:0] t;
		logic [63:0] e;
		logic [63:0] g;
		t = (cfg_thresh == '0) ? 64'd1 : 64'(cfg_thresh);   // zero threshold reads as one
		e = 64'(env);
		if (e < (t << ENV_FRAC))
			return GAIN_ONE;
		if (op == OP_EXPAND)
			g = (e << EXP_SHIFT) / t;
		else
			g = root_floor((t << (ENV_FRAC + 2 * GAIN_FRAC)) / e);
		if (g < 64'(cfg_floor))
			return cfg_floor;
		if (g > 64'(cfg_ceil))
			return cfg_ceil;
		return g[GAIN_BITS-1:0];
	endfunction

	// Expected result of one request; advances the envelope of the chosen path.
	function automatic result_t compand_sample(input logic op, input logic [SAMPLE_BITS-1:0] smp);
		result_t             r;
		logic [63:0]         mag;
		logic [63:0]         prod;
		logic [GAIN_BITS-1:0] g;
		logic [ENV_BITS-1:0] env;
		logic                neg;
		neg = smp[SAMPLE_BITS-1];
		mag = neg ? ((64'd1 << SAMPLE_BITS) - 64'(smp)) : 64'(smp);
		if (op == OP_EXPAND) begin
			env_exp = track_envelope(env_exp, mag);
			env = env_exp;
		end else begin
			env_comp = track_envelope(env_comp, mag);
			env = env_comp;
		end
		g = gain_for_env(env, op);
		prod = (mag * 64'(g)) >> GAIN_FRAC;   // truncates the magnitude toward zero
		r.saturated = 1'b0;
		if (neg) begin
			if (prod > NEG_LIMIT) begin
				prod = NEG_LIMIT;
				r.saturated = 1'b1;
			end
			prod = -prod;
		end else if (prod > POS_LIMIT) begin
			prod = POS_LIMIT;
			r.saturated = 1'b1;
		end
		r.sample_out = prod[SAMPLE_BITS-1:0];
		r.gain_applied = g;
		return r;
	endfunction

	// APB write: setup cycle, then access; register lands on the access edge.
	// Only called while the block is idle, aligned to a rising edge.
	task automatic write_reg(input logic [2:0] idx, input logic [DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ATTACK:  cfg_attack  = value[COEFF_BITS-1:0];
			REG_RELEASE: cfg_release = value[COEFF_BITS-1:0];
			REG_THRESH:  cfg_thresh  = value[THR_BITS-1:0];
			REG_FLOOR:   cfg_floor   = value[GAIN_BITS-1:0];
			REG_CEIL:    cfg_ceil    = value[GAIN_BITS-1:0];
			default: ;   // unmapped: no effect
		endcase
		@(posedge clk);
	endtask

	// Offer one request after a random gap; junk rides the bus while valid is low.
	// valid is left high on return, so a back-to-back request never toggles it.
	task automatic send_request(input logic op, input logic [SAMPLE_BITS-1:0] smp);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			sample_ch.valid     <= 1'b0;
			sample_ch.op        <= 1'($urandom);
			sample_ch.sample_in <= SAMPLE_BITS'($urandom);
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.op        <= op;
		sample_ch.sample_in <= smp;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		pending_results.push_back(compand_sample(op, smp));
	endtask

	// Drop valid and wait for every outstanding result; the block is then idle.
	task automatic drain_requests();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: fresh stall per result, compare against the oldest expectation.
	initial begin : result_check
		result_t want;
		int      stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			if (pending_results.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("unexpected result: out=%0d gain=%0d sat=%0b",
						result_ch.sample_out, result_ch.gain_applied, result_ch.saturated);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (want.sample_out !== result_ch.sample_out ||
					want.gain_applied !== result_ch.gain_applied ||
					want.saturated !== result_ch.saturated) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("mismatch: want out=%0d gain=%0d sat=%0b, got out=%0d gain=%0d sat=%0b",
							want.sample_out, want.gain_applied, want.saturated,
							result_ch.sample_out, result_ch.gain_applied, result_ch.saturated);
					mismatch_count++;
				end
			end
		end
	end

	// Reset defaults: quiet and full-scale samples on compress, full-scale and single-LSB samples on expand.
	task automatic test_reset_defaults();
		send_request(OP_COMPRESS, 16'h0000);
		send_request(OP_COMPRESS, 16'h7FFF);
		send_request(OP_COMPRESS, 16'h8000);
		send_request(OP_EXPAND, 16'h7FFF);
		send_request(OP_EXPAND, 16'h8000);
		send_request(OP_EXPAND, 16'hFFFF);
		send_request(OP_EXPAND, 16'h0001);
	endtask

	// Coefficient extremes: instant attack with frozen release, then the reverse.
	task automatic test_coeff_extremes();
		drain_requests();
		write_reg(REG_ATTACK, 32'h00FF_FFFF);
		write_reg(REG_RELEASE, 32'h0000_0000);
		send_request(OP_COMPRESS, 16'h8000);
		send_request(OP_COMPRESS, 16'h7FFF);
		send_request(OP_EXPAND, 16'h7FFF);
		send_request(OP_EXPAND, 16'h0001);   // release 0: envelope holds
		drain_requests();
		write_reg(REG_ATTACK, 32'h0000_0000);
		write_reg(REG_RELEASE, 32'h00FF_FFFF);
		send_request(OP_COMPRESS, 16'h7FFF);   // attack 0: no rise
		send_request(OP_COMPRESS, 16'h0000);   // release max: falls almost fully
	endtask

	// Zero threshold behaves as a threshold of one.
	task automatic test_zero_threshold();
		drain_requests();
		write_reg(REG_ATTACK, 32'h00FF_FFFF);
		write_reg(REG_THRESH, 32'h0000_0000);
		write_reg(REG_FLOOR, 32'h0000_0000);
		write_reg(REG_CEIL, 32'h0000_FFFF);
		send_request(OP_COMPRESS, 16'h0100);
		send_request(OP_EXPAND, 16'hFF00);
	endtask

	// Floor above ceiling: low gain snaps to floor, high gain to ceiling.
	task automatic test_floor_over_ceiling();
		drain_requests();
		write_reg(REG_THRESH, 32'd100);
		write_reg(REG_FLOOR, 32'd60000);
		write_reg(REG_CEIL, 32'd100);
		send_request(OP_COMPRESS, 16'h7FFF);
		send_request(OP_EXPAND, 16'h8000);
	endtask

	// Huge expand gain must clamp before use; also a zero ceiling that mutes.
	task automatic test_expand_clamp();
		drain_requests();
		write_reg(REG_THRESH, 32'd1);
		write_reg(REG_FLOOR, 32'd0);
		write_reg(REG_CEIL, 32'h0000_FFFF);
		send_request(OP_EXPAND, 16'h7FFF);
		send_request(OP_EXPAND, 16'h8000);
		drain_requests();
		write_reg(REG_CEIL, 32'd0);
		send_request(OP_COMPRESS, 16'h4000);
	endtask

	// Threshold at or above full scale: envelope never gets there, gain stays unity.
	task automatic test_high_threshold();
		drain_requests();
		write_reg(REG_CEIL, 32'd49152);
		write_reg(REG_THRESH, 32'h0000_FFFF);
		send_request(OP_COMPRESS, 16'h8000);
		drain_requests();
		write_reg(REG_THRESH, 32'd32768);
		send_request(OP_EXPAND, 16'h8000);
	endtask

	// Writes to unmapped addresses must not disturb any register.
	task automatic test_unmapped_writes();
		drain_requests();
		write_reg(REG_THRESH, 32'd3277);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_MID, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0000_0000);
		send_request(OP_COMPRESS, 16'h7FFF);
	endtask

	// New random register set, weighted toward extremes and useful ranges.
	task automatic randomize_settings();
		logic [DATA_BITS-1:0] v;
		logic [DATA_BITS-1:0] lo;
		logic [DATA_BITS-1:0] hi;
		case ($urandom_range(0, 4))
			0: v = 32'd0;
			1: v = 32'h00FF_FFFF;
			2: v = $urandom_range(32'h0010_0000, 32'h00FF_FFFF);
			default: v = $urandom;   // upper bits must be dropped
		endcase
		write_reg(REG_ATTACK, v);
		case ($urandom_range(0, 4))
			0: v = 32'd0;
			1: v = 32'h00FF_FFFF;
			2: v = $urandom_range(0, 32'h0010_0000);
			default: v = $urandom;
		endcase
		write_reg(REG_RELEASE, v);
		case ($urandom_range(0, 6))
			0: v = 32'd0;
			1: v = 32'd1;
			2: v = 32'h0000_FFFF;
			3: v = 32'd32768;
			4: v = $urandom_range(1, 32768);
			default: v = $urandom_range(1, 4000);
		endcase
		write_reg(REG_THRESH, v);
		case ($urandom_range(0, 5))
			0: begin
				lo = $urandom;   // arbitrary, possibly inverted
				hi = $urandom;
			end
			1: begin
				lo = 32'd0;
				hi = 32'h0000_FFFF;
			end
			default: begin
				lo = $urandom_range(0, 16384);
				hi = $urandom_range(16384, 65535);
			end
		endcase
		write_reg(REG_FLOOR, lo);
		write_reg(REG_CEIL, hi);
	endtask

	// Random phases: bursts of sustained level so envelopes cross the threshold,
	// mixed with quiet stretches and raw noise. Both sides go calm now and then.
	task automatic test_random_program();
		int                   left;
		int                   len;
		int                   level;
		int                   m;
		int                   shape;
		logic                 op;
		logic                 sticky;
		logic [SAMPLE_BITS-1:0] smp;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_requests();
			randomize_settings();
			left = PHASE_ITEMS;
			while (left > 0) begin
				len = $urandom_range(3, 24);
				if (len > left)
					len = left;
				shape = $urandom_range(0, 4);
				case (shape)
					0: level = $urandom_range(0, 2000);
					1: level = $urandom_range(0, 32768);
					default: level = $urandom_range(24000, 32768);
				endcase
				sticky = ($urandom_range(0, 2) != 0);
				op = 1'($urandom);
				calm = ($urandom_range(0, 4) == 0);
				for (int k = 0; k < len; k++) begin
					if (!sticky)
						op = 1'($urandom);
					if (shape == 4) begin
						smp = SAMPLE_BITS'($urandom);   // raw noise
					end else begin
						m = level * int'($urandom_range(60, 100)) / 100;
						if ($urandom_range(0, 1) == 1)
							smp = SAMPLE_BITS'(-m);
						else
							smp = SAMPLE_BITS'((m > 32767) ? 32767 : m);
					end
					send_request(op, smp);
				end
				left -= len;
			end
			calm = 1'b0;
		end
	endtask

	initial begin : run_tests
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.op        = OP_COMPRESS;
		sample_ch.sample_in = '0;
		calm                = 1'b0;
		mismatch_count      = 0;
		cfg_attack          = ATTACK_RST;
		cfg_release         = RELEASE_RST;
		cfg_thresh          = THRESH_RST;
		cfg_floor           = FLOOR_RST;
		cfg_ceil            = CEIL_RST;
		env_comp            = '0;
		env_exp             = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_coeff_extremes();
		test_zero_threshold();
		test_floor_over_ceiling();
		test_expand_clamp();
		test_high_threshold();
		test_unmapped_writes();
		test_random_program();

		// Let any stray result show up before judging.
		drain_requests();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/acg_pkg.sv
hw/rtl/acg_req_if.sv
hw/rtl/acg_res_if.sv
hw/rtl/audio_compander_envelope_gain.sv
dv/audio_compander_envelope_gain_tb.sv
